// ----- src/tac_pkg.sv -----
// Shared types, constants and the solve step table for the touch affine calibration block.
// No dependencies; every other file imports this package.
package tac_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int MIN_POINTS     = 3;
  localparam int RAW_BITS       = 12;
  localparam int FRAC_BITS      = 16;
  localparam int REF_W          = 16;
  localparam int SCR_W          = 16;
  localparam int CNT_W          = 5;
  localparam int SRAW_W         = 17;
  localparam int SREF_W         = 21;
  localparam int SSQ_W          = 29;
  localparam int SCRS_W         = 33;
  localparam int GAIN_W         = 32;
  localparam int OFF_W          = 48;
  localparam int MUL_W          = 40;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int NUM_W          = 92;
  localparam int DEN_W          = 72;
  localparam int VACC_W         = 50;
  localparam int SOLVE_STEPS    = 30;
  localparam int STEP_W         = 5;
  localparam int QDEPTH         = 2;
  localparam int NSRC           = 24;

  typedef enum logic [1:0] {
    OP_APPLY,
    OP_ADD,
    OP_SOLVE,
    OP_IDENT
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FEW,
    ST_DEGEN,
    ST_FULL
  } status_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_APPLY,
    B_ADD,
    B_MUL_GO,
    B_MUL_WAIT,
    B_STORE,
    B_DIV_WAIT,
    B_FIN
  } bst_e;

  typedef enum logic [4:0] {
    S_N, S_SXX, S_SXY, S_SYY, S_SX, S_SY, S_SRX, S_SRY,
    S_C0, S_C1, S_C2, S_C3,
    S_CXX, S_CXY, S_CYY, S_XU, S_YU, S_XV, S_YV,
    S_GA, S_GB, S_GD, S_GE, S_ONEQ
  } src_e;

  typedef enum logic [3:0] {
    D_NONE, D_CXX, D_CXY, D_CYY, D_XU, D_YU, D_XV, D_YV, D_DET,
    D_GA, D_GB, D_GD, D_GE, D_OX, D_OY
  } dst_e;

  typedef struct packed {
    op_e                       op;
    logic [RAW_BITS-1:0]       raw_x;
    logic [RAW_BITS-1:0]       raw_y;
    logic signed [REF_W-1:0]   ref_x;
    logic signed [REF_W-1:0]   ref_y;
  } item_t;

  typedef struct packed {
    src_e a;
    src_e b;
    logic first;
    dst_e dst;
  } uop_t;

  function automatic uop_t solve_uop(input logic [STEP_W-1:0] s);
    uop_t u;
    unique case (s)
      5'd0:    u = '{S_N,   S_SXX, 1'b1, D_NONE};
      5'd1:    u = '{S_SX,  S_SX,  1'b0, D_CXX};
      5'd2:    u = '{S_N,   S_SXY, 1'b1, D_NONE};
      5'd3:    u = '{S_SX,  S_SY,  1'b0, D_CXY};
      5'd4:    u = '{S_N,   S_SYY, 1'b1, D_NONE};
      5'd5:    u = '{S_SY,  S_SY,  1'b0, D_CYY};
      5'd6:    u = '{S_N,   S_C0,  1'b1, D_NONE};
      5'd7:    u = '{S_SX,  S_SRX, 1'b0, D_XU};
      5'd8:    u = '{S_N,   S_C1,  1'b1, D_NONE};
      5'd9:    u = '{S_SY,  S_SRX, 1'b0, D_YU};
      5'd10:   u = '{S_N,   S_C2,  1'b1, D_NONE};
      5'd11:   u = '{S_SX,  S_SRY, 1'b0, D_XV};
      5'd12:   u = '{S_N,   S_C3,  1'b1, D_NONE};
      5'd13:   u = '{S_SY,  S_SRY, 1'b0, D_YV};
      5'd14:   u = '{S_CXX, S_CYY, 1'b1, D_NONE};
      5'd15:   u = '{S_CXY, S_CXY, 1'b0, D_DET};
      5'd16:   u = '{S_CYY, S_XU,  1'b1, D_NONE};
      5'd17:   u = '{S_CXY, S_YU,  1'b0, D_GA};
      5'd18:   u = '{S_CXX, S_YU,  1'b1, D_NONE};
      5'd19:   u = '{S_CXY, S_XU,  1'b0, D_GB};
      5'd20:   u = '{S_CYY, S_XV,  1'b1, D_NONE};
      5'd21:   u = '{S_CXY, S_YV,  1'b0, D_GD};
      5'd22:   u = '{S_CXX, S_YV,  1'b1, D_NONE};
      5'd23:   u = '{S_CXY, S_XV,  1'b0, D_GE};
      5'd24:   u = '{S_SRX, S_ONEQ, 1'b1, D_NONE};
      5'd25:   u = '{S_GA,  S_SX,  1'b0, D_NONE};
      5'd26:   u = '{S_GB,  S_SY,  1'b0, D_OX};
      5'd27:   u = '{S_SRY, S_ONEQ, 1'b1, D_NONE};
      5'd28:   u = '{S_GD,  S_SX,  1'b0, D_NONE};
      5'd29:   u = '{S_GE,  S_SY,  1'b0, D_OY};
      default: u = '{S_N,   S_N,   1'b1, D_NONE};
    endcase
    return u;
  endfunction

endpackage

// ----- src/touch_affine_calibration_top.sv -----
// Apply: four products on the shared 33x13 multiplier; the back end takes no new item until
// the current one has finished. Add point: seven products on that multiplier.
// Solve: up to 30 passes through the bit-serial 40x40 multiplier and up to six passes
// through the bit-serial divider.
// Reset (rst_ni low, asynchronous): clears the queue and point sums, loads identity coefficients.
module touch_affine_calibration_top #(
  parameter int MAX_POINTS = tac_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic [tac_pkg::RAW_BITS-1:0]      raw_x_i,
  input  logic [tac_pkg::RAW_BITS-1:0]      raw_y_i,
  input  logic signed [tac_pkg::REF_W-1:0]  ref_x_i,
  input  logic signed [tac_pkg::REF_W-1:0]  ref_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tac_pkg::SCR_W-1:0]  screen_x_o,
  output logic signed [tac_pkg::SCR_W-1:0]  screen_y_o,
  output logic [1:0]                        status_o,
  output logic                              is_identity_o,
  output logic [tac_pkg::CNT_W-1:0]         points_held_o
);
  import tac_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  tac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .raw_x_i      (raw_x_i),
    .raw_y_i      (raw_y_i),
    .ref_x_i      (ref_x_i),
    .ref_y_i      (ref_y_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  tac_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .status_o      (status_o),
    .is_identity_o (is_identity_o),
    .points_held_o (points_held_o)
  );

`ifndef ASSERT_OFF
  a_full_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> points_held_o == CNT_W'(MAX_POINTS))
    else $error("full status with count below limit");

  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FEW || status_o == ST_DEGEN) |-> points_held_o == '0)
    else $error("failed solve kept points");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> points_held_o <= CNT_W'(MAX_POINTS))
    else $error("point count above limit");

  a_fail_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("screen output on non-apply result");
`endif

endmodule

// ----- src/tac_front.sv -----
// Front end: accepts input words, decodes the operation and queues items for the back end.
// Depends on tac_pkg.
module tac_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [tac_pkg::RAW_BITS-1:0]  raw_x_i,
  input  logic [tac_pkg::RAW_BITS-1:0]  raw_y_i,
  input  logic signed [tac_pkg::REF_W-1:0] ref_x_i,
  input  logic signed [tac_pkg::REF_W-1:0] ref_y_i,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output tac_pkg::item_t                item_o
);
  import tac_pkg::*;

  item_t       fifo_q [QDEPTH];
  item_t       in_item;
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  always_comb begin
    in_item.op    = op_e'(operation_i);
    in_item.raw_x = raw_x_i;
    in_item.raw_y = raw_y_i;
    in_item.ref_x = ref_x_i;
    in_item.ref_y = ref_y_i;
  end

  assign in_ready_o   = (cnt_q != 2'(QDEPTH));
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;
  assign cnt_d        = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= in_item;
  end

endmodule

// ----- src/tac_smul.sv -----
// Shift-and-add signed multiplier, one multiplier bit per cycle, for the solve sequence.
// Depends on tac_pkg.
module tac_smul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tac_pkg::MUL_W-1:0]  a_i,
  input  logic signed [tac_pkg::MUL_W-1:0]  b_i,
  output logic                              done_o,
  output logic signed [tac_pkg::PROD_W-1:0] prod_o
);
  import tac_pkg::*;

  localparam int CW = $clog2(MUL_W + 1);

  logic              busy_q, done_q, neg_q;
  logic [CW-1:0]     cnt_q;
  logic [PROD_W-1:0] mcand_q, acc_q;
  logic [MUL_W-1:0]  mplier_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [MUL_W-1:0]  ua, ub;

  assign ua = a_i[MUL_W-1] ? MUL_W'(-a_i) : MUL_W'(a_i);
  assign ub = b_i[MUL_W-1] ? MUL_W'(-b_i) : MUL_W'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MUL_W);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q    <= a_i[MUL_W-1] ^ b_i[MUL_W-1];
      mcand_q  <= PROD_W'(ua);
      mplier_q <= ub;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        prod_q <= neg_q ? PROD_W'(-acc_q) : PROD_W'(acc_q);
      end else begin
        if (mplier_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ----- src/tac_div.sv -----
// Restoring divider, one quotient bit per cycle, with round half away from zero and saturation.
// Depends on tac_pkg.
module tac_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tac_pkg::NUM_W-1:0]  num_i,
  input  logic [tac_pkg::DEN_W-1:0]         den_i,
  input  logic                              wide_lim_i,
  output logic                              done_o,
  output logic signed [tac_pkg::OFF_W-1:0]  quo_o
);
  import tac_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic              busy_q, done_q, neg_q, wide_q;
  logic [CW-1:0]     cnt_q;
  logic [NUM_W-1:0]  mag_q, quo_q;
  logic [DEN_W-1:0]  rem_q, den_q;
  logic signed [OFF_W-1:0] res_q;

  logic [DEN_W:0]    r2, rdiff;
  logic              ge;
  logic              up;
  logic [NUM_W:0]    q1, cap, qs;

  always_comb begin
    r2    = {rem_q, mag_q[NUM_W-1]};
    rdiff = r2 - {1'b0, den_q};
    ge    = (r2 >= {1'b0, den_q});
    up    = ({rem_q, 1'b0} >= {1'b0, den_q});
    q1    = {1'b0, quo_q} + (NUM_W+1)'(up);
    cap   = wide_q ? (((NUM_W+1)'(1) << (OFF_W - 1)) - (NUM_W+1)'(1))
                   : (((NUM_W+1)'(1) << (GAIN_W - 1)) - (NUM_W+1)'(1));
    cap   = cap + (NUM_W+1)'(neg_q);
    qs    = (q1 > cap) ? cap : q1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[NUM_W-1];
      wide_q <= wide_lim_i;
      mag_q  <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      den_q  <= den_i;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        res_q <= neg_q ? OFF_W'(-qs[OFF_W-1:0]) : OFF_W'(qs[OFF_W-1:0]);
      end else begin
        rem_q <= ge ? rdiff[DEN_W-1:0] : r2[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], ge};
        mag_q <= mag_q << 1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

// ----- src/tac_back.sv -----
// Back end: point sums, coefficients, apply and add datapath, solve sequencer and result register.
// Depends on tac_pkg, tac_smul and tac_div.
module tac_back #(
  parameter int MAX_POINTS = tac_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  tac_pkg::item_t                   item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [tac_pkg::SCR_W-1:0] screen_x_o,
  output logic signed [tac_pkg::SCR_W-1:0] screen_y_o,
  output logic [1:0]                       status_o,
  output logic                             is_identity_o,
  output logic [tac_pkg::CNT_W-1:0]        points_held_o
);
  import tac_pkg::*;

  localparam int SMA_W = GAIN_W + 1;
  localparam int SMB_W = RAW_BITS + 1;
  localparam int SMP_W = SMA_W + SMB_W;
  localparam int MC_W  = 3;
  localparam int APPLY_PRODS = 4;
  localparam int ADD_PRODS   = 7;
  localparam logic signed [GAIN_W-1:0] ONE_G = GAIN_W'(1) << FRAC_BITS;

  bst_e    state_q, state_d;
  op_e     op_q;
  status_e stat_q;
  item_t   itm_q;
  logic [MC_W-1:0]   mcnt_q;
  logic [STEP_W-1:0] step_q;

  logic [CNT_W-1:0]         count_q;
  logic [SRAW_W-1:0]        sx_q, sy_q;
  logic signed [SREF_W-1:0] srx_q, sry_q;
  logic [SSQ_W-1:0]         sxx_q, sxy_q, syy_q;
  logic signed [SCRS_W-1:0] scr_q [4];
  logic signed [GAIN_W-1:0] gain_q [4];
  logic signed [OFF_W-1:0]  off_q [2];

  logic signed [SMA_W-1:0]  sm_a;
  logic signed [SMB_W-1:0]  sm_b;
  logic signed [SMP_W-1:0]  sm_p, prod_q;
  logic signed [VACC_W-1:0] vx_q, vy_q;

  logic signed [NUM_W-1:0]  acc_q;
  logic signed [MUL_W-1:0]  cxx_q, cxy_q, cyy_q, xu_q, yu_q, xv_q, yv_q;
  logic [DEN_W-1:0]         det_q;
  logic signed [MUL_W-1:0]  opnd [NSRC];

  logic                     ovalid_q, ido_q;
  logic signed [SCR_W-1:0]  sxo_q, syo_q;
  logic [1:0]               sto_q;
  logic [CNT_W-1:0]         pho_q;

  uop_t uop;
  logic mul_go, mul_done, div_go, div_done, fin_go;
  logic pts_full, pts_few, det_bad, last_step, div_wide, at_ident;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]         div_den;
  logic signed [OFF_W-1:0]  div_q;

  function automatic logic signed [SCR_W-1:0] round_sat(input logic signed [VACC_W-1:0] v);
    logic [VACC_W-1:0] mag, r, lim, sat;
    mag = v[VACC_W-1] ? VACC_W'(-v) : VACC_W'(v);
    r   = (mag + (VACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = (VACC_W'(1) << (SCR_W - 1)) - VACC_W'(!v[VACC_W-1]);
    sat = (r > lim) ? lim : r;
    return v[VACC_W-1] ? SCR_W'(-sat[SCR_W-1:0]) : SCR_W'(sat[SCR_W-1:0]);
  endfunction

  assign uop       = solve_uop(step_q);
  assign pts_full  = (count_q >= CNT_W'(MAX_POINTS));
  assign pts_few   = (count_q < CNT_W'(MIN_POINTS));
  assign det_bad   = acc_q[NUM_W-1] || (acc_q == '0);
  assign last_step = (step_q == STEP_W'(SOLVE_STEPS - 1));
  assign div_wide  = (uop.dst == D_OX) || (uop.dst == D_OY);
  assign div_num   = div_wide ? acc_q : (acc_q <<< FRAC_BITS);
  assign div_den   = div_wide ? DEN_W'(count_q) : det_q;
  assign at_ident  = (gain_q[0] == ONE_G) && (gain_q[1] == '0) && (gain_q[2] == '0) &&
                     (gain_q[3] == ONE_G) && (off_q[0] == '0) && (off_q[1] == '0);
  assign item_ready_o = (state_q == B_IDLE);

  always_comb begin
    opnd[S_N]    = MUL_W'($signed({1'b0, count_q}));
    opnd[S_SXX]  = MUL_W'($signed({1'b0, sxx_q}));
    opnd[S_SXY]  = MUL_W'($signed({1'b0, sxy_q}));
    opnd[S_SYY]  = MUL_W'($signed({1'b0, syy_q}));
    opnd[S_SX]   = MUL_W'($signed({1'b0, sx_q}));
    opnd[S_SY]   = MUL_W'($signed({1'b0, sy_q}));
    opnd[S_SRX]  = MUL_W'(srx_q);
    opnd[S_SRY]  = MUL_W'(sry_q);
    opnd[S_C0]   = MUL_W'(scr_q[0]);
    opnd[S_C1]   = MUL_W'(scr_q[1]);
    opnd[S_C2]   = MUL_W'(scr_q[2]);
    opnd[S_C3]   = MUL_W'(scr_q[3]);
    opnd[S_CXX]  = cxx_q;
    opnd[S_CXY]  = cxy_q;
    opnd[S_CYY]  = cyy_q;
    opnd[S_XU]   = xu_q;
    opnd[S_YU]   = yu_q;
    opnd[S_XV]   = xv_q;
    opnd[S_YV]   = yv_q;
    opnd[S_GA]   = MUL_W'(gain_q[0]);
    opnd[S_GB]   = MUL_W'(gain_q[1]);
    opnd[S_GD]   = MUL_W'(gain_q[2]);
    opnd[S_GE]   = MUL_W'(gain_q[3]);
    opnd[S_ONEQ] = MUL_W'(1) << FRAC_BITS;
  end

  tac_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (opnd[uop.a]),
    .b_i     (opnd[uop.b]),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  tac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .num_i      (div_num),
    .den_i      (div_den),
    .wide_lim_i (div_wide),
    .done_o     (div_done),
    .quo_o      (div_q)
  );

  always_comb begin
    sm_a = '0;
    sm_b = '0;
    if (state_q == B_APPLY) begin
      case (mcnt_q)
        3'd0:    begin sm_a = SMA_W'(gain_q[0]); sm_b = SMB_W'($signed({1'b0, itm_q.raw_x})); end
        3'd1:    begin sm_a = SMA_W'(gain_q[1]); sm_b = SMB_W'($signed({1'b0, itm_q.raw_y})); end
        3'd2:    begin sm_a = SMA_W'(gain_q[2]); sm_b = SMB_W'($signed({1'b0, itm_q.raw_x})); end
        default: begin sm_a = SMA_W'(gain_q[3]); sm_b = SMB_W'($signed({1'b0, itm_q.raw_y})); end
      endcase
    end else begin
      case (mcnt_q)
        3'd0: begin
          sm_a = SMA_W'($signed({1'b0, itm_q.raw_x}));
          sm_b = SMB_W'($signed({1'b0, itm_q.raw_x}));
        end
        3'd1: begin
          sm_a = SMA_W'($signed({1'b0, itm_q.raw_x}));
          sm_b = SMB_W'($signed({1'b0, itm_q.raw_y}));
        end
        3'd2: begin
          sm_a = SMA_W'($signed({1'b0, itm_q.raw_y}));
          sm_b = SMB_W'($signed({1'b0, itm_q.raw_y}));
        end
        3'd3:    begin sm_a = SMA_W'(itm_q.ref_x); sm_b = SMB_W'($signed({1'b0, itm_q.raw_x})); end
        3'd4:    begin sm_a = SMA_W'(itm_q.ref_x); sm_b = SMB_W'($signed({1'b0, itm_q.raw_y})); end
        3'd5:    begin sm_a = SMA_W'(itm_q.ref_y); sm_b = SMB_W'($signed({1'b0, itm_q.raw_x})); end
        default: begin sm_a = SMA_W'(itm_q.ref_y); sm_b = SMB_W'($signed({1'b0, itm_q.raw_y})); end
      endcase
    end
  end

  assign sm_p = sm_a * sm_b;

  always_comb begin
    state_d = state_q;
    mul_go  = 1'b0;
    div_go  = 1'b0;
    fin_go  = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.op)
            OP_APPLY: state_d = B_APPLY;
            OP_ADD:   state_d = pts_full ? B_FIN : B_ADD;
            OP_SOLVE: state_d = pts_few ? B_FIN : B_MUL_GO;
            OP_IDENT: state_d = B_FIN;
          endcase
        end
      end
      B_APPLY: if (mcnt_q == MC_W'(APPLY_PRODS)) state_d = B_FIN;
      B_ADD:   if (mcnt_q == MC_W'(ADD_PRODS)) state_d = B_FIN;
      B_MUL_GO: begin
        mul_go  = 1'b1;
        state_d = B_MUL_WAIT;
      end
      B_MUL_WAIT: if (mul_done) state_d = B_STORE;
      B_STORE: begin
        unique case (uop.dst) inside
          D_DET: state_d = det_bad ? B_FIN : B_MUL_GO;
          D_GA, D_GB, D_GD, D_GE, D_OX, D_OY: begin
            div_go  = 1'b1;
            state_d = B_DIV_WAIT;
          end
          default: state_d = B_MUL_GO;
        endcase
      end
      B_DIV_WAIT: if (div_done) state_d = last_step ? B_FIN : B_MUL_GO;
      B_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          fin_go  = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      op_q      <= OP_APPLY;
      stat_q    <= ST_OK;
      mcnt_q    <= '0;
      step_q    <= '0;
      ovalid_q  <= 1'b0;
      count_q   <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      srx_q     <= '0;
      sry_q     <= '0;
      sxx_q     <= '0;
      sxy_q     <= '0;
      syy_q     <= '0;
      for (int i = 0; i < 4; i++) scr_q[i] <= '0;
      gain_q[0] <= ONE_G;
      gain_q[1] <= '0;
      gain_q[2] <= '0;
      gain_q[3] <= ONE_G;
      off_q[0]  <= '0;
      off_q[1]  <= '0;
    end else begin
      state_q <= state_d;
      if (fin_go) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;

      unique case (state_q)
        B_IDLE: begin
          if (item_valid_i) begin
            op_q   <= item_i.op;
            mcnt_q <= '0;
            step_q <= '0;
            stat_q <= ST_OK;
            unique case (item_i.op)
              OP_ADD: begin
                if (pts_full) begin
                  stat_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CNT_W'(1);
                  sx_q    <= sx_q + SRAW_W'(item_i.raw_x);
                  sy_q    <= sy_q + SRAW_W'(item_i.raw_y);
                  srx_q   <= srx_q + SREF_W'(item_i.ref_x);
                  sry_q   <= sry_q + SREF_W'(item_i.ref_y);
                end
              end
              OP_SOLVE: if (pts_few) stat_q <= ST_FEW;
              OP_IDENT: begin
                gain_q[0] <= ONE_G;
                gain_q[1] <= '0;
                gain_q[2] <= '0;
                gain_q[3] <= ONE_G;
                off_q[0]  <= '0;
                off_q[1]  <= '0;
              end
              OP_APPLY: ;
            endcase
          end
        end
        B_APPLY: mcnt_q <= mcnt_q + MC_W'(1);
        B_ADD: begin
          mcnt_q <= mcnt_q + MC_W'(1);
          case (mcnt_q)
            3'd1:    sxx_q    <= sxx_q + prod_q[SSQ_W-1:0];
            3'd2:    sxy_q    <= sxy_q + prod_q[SSQ_W-1:0];
            3'd3:    syy_q    <= syy_q + prod_q[SSQ_W-1:0];
            3'd4:    scr_q[0] <= scr_q[0] + prod_q[SCRS_W-1:0];
            3'd5:    scr_q[1] <= scr_q[1] + prod_q[SCRS_W-1:0];
            3'd6:    scr_q[2] <= scr_q[2] + prod_q[SCRS_W-1:0];
            3'd7:    scr_q[3] <= scr_q[3] + prod_q[SCRS_W-1:0];
            default: ;
          endcase
        end
        B_STORE: begin
          if (uop.dst == D_DET && det_bad) stat_q <= ST_DEGEN;
          if (state_d == B_MUL_GO) step_q <= step_q + STEP_W'(1);
        end
        B_DIV_WAIT: begin
          if (div_done) begin
            case (uop.dst)
              D_GA:    gain_q[0] <= div_q[GAIN_W-1:0];
              D_GB:    gain_q[1] <= div_q[GAIN_W-1:0];
              D_GD:    gain_q[2] <= div_q[GAIN_W-1:0];
              D_GE:    gain_q[3] <= div_q[GAIN_W-1:0];
              D_OX:    off_q[0]  <= div_q;
              D_OY:    off_q[1]  <= div_q;
              default: ;
            endcase
            if (state_d == B_MUL_GO) step_q <= step_q + STEP_W'(1);
          end
        end
        B_FIN: begin
          if (fin_go && op_q == OP_SOLVE) begin
            count_q <= '0;
            sx_q    <= '0;
            sy_q    <= '0;
            srx_q   <= '0;
            sry_q   <= '0;
            sxx_q   <= '0;
            sxy_q   <= '0;
            syy_q   <= '0;
            for (int i = 0; i < 4; i++) scr_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sm_p;
    if (state_q == B_IDLE && item_valid_i) itm_q <= item_i;
    if (state_q == B_APPLY) begin
      case (mcnt_q)
        3'd1:    vx_q <= VACC_W'(off_q[0]) + VACC_W'(prod_q);
        3'd2:    vx_q <= vx_q + VACC_W'(prod_q);
        3'd3:    vy_q <= VACC_W'(off_q[1]) + VACC_W'(prod_q);
        3'd4:    vy_q <= vy_q + VACC_W'(prod_q);
        default: ;
      endcase
    end
    if (state_q == B_MUL_WAIT && mul_done) begin
      acc_q <= uop.first ? NUM_W'(mul_p) : (acc_q - NUM_W'(mul_p));
    end
    if (state_q == B_STORE) begin
      case (uop.dst)
        D_CXX:   cxx_q <= acc_q[MUL_W-1:0];
        D_CXY:   cxy_q <= acc_q[MUL_W-1:0];
        D_CYY:   cyy_q <= acc_q[MUL_W-1:0];
        D_XU:    xu_q  <= acc_q[MUL_W-1:0];
        D_YU:    yu_q  <= acc_q[MUL_W-1:0];
        D_XV:    xv_q  <= acc_q[MUL_W-1:0];
        D_YV:    yv_q  <= acc_q[MUL_W-1:0];
        D_DET:   det_q <= acc_q[DEN_W-1:0];
        default: ;
      endcase
    end
    if (fin_go) begin
      sxo_q <= (op_q == OP_APPLY) ? round_sat(vx_q) : '0;
      syo_q <= (op_q == OP_APPLY) ? round_sat(vy_q) : '0;
      sto_q <= stat_q;
      ido_q <= at_ident;
      pho_q <= (op_q == OP_SOLVE) ? '0 : count_q;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign screen_x_o    = sxo_q;
  assign screen_y_o    = syo_q;
  assign status_o      = sto_q;
  assign is_identity_o = ido_q;
  assign points_held_o = pho_q;

endmodule
